>>> rtl/core/fk_pkg.sv
// ----------------------------------------------------------------------------
// fk_pkg: shared types, constants and fixed-point helpers
// Holds the Q-format types and the rounding and saturation helpers used by the
// pipeline stages. Also holds the polynomial sine and cosine used to build the
// trig lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package fk_pkg;

    // Q1.14 trig value (magnitude at most 16384)
    typedef logic signed [15:0] t_trig;
    // wide signed Q14 intermediate; the chained sums stay below 2^18
    typedef logic signed [19:0] t_fx;
    // one configuration register
    typedef logic [9:0] t_len;

    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_PI   = 2'd1,
        ADJ_NEG  = 2'd2
    } t_adj;

    typedef enum logic [1:0] {
        REG_BASE   = 2'd0,
        REG_UPPER  = 2'd1,
        REG_FORE   = 2'd2,
        REG_FLANGE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_len base;
        t_len upper;
        t_len fore;
        t_len flange;
    } t_cfg;

    // sines and cosines of the last three joints
    typedef struct packed {
        t_trig s4;
        t_trig c4;
        t_trig s5;
        t_trig c5;
        t_trig s6;
        t_trig c6;
    } t_wrist;

    // inputs of one pose row: three partial products and the upper-arm term
    typedef struct packed {
        t_fx p;
        t_fx q;
        t_fx r;
        t_fx ext;
    } t_row_in;

    typedef struct packed {
        logic signed [15:0] rot0;
        logic signed [15:0] rot1;
        logic signed [15:0] rot2;
        logic signed [16:0] pos;
    } t_row_out;

    typedef struct packed {
        logic signed [15:0] rot_xx;
        logic signed [15:0] rot_xy;
        logic signed [15:0] rot_xz;
        logic signed [15:0] rot_yx;
        logic signed [15:0] rot_yy;
        logic signed [15:0] rot_yz;
        logic signed [15:0] rot_zx;
        logic signed [15:0] rot_zy;
        logic signed [15:0] rot_zz;
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
    } t_pose;

    localparam t_len RST_BASE   = 10'd360;
    localparam t_len RST_UPPER  = 10'd420;
    localparam t_len RST_FORE   = 10'd400;
    localparam t_len RST_FLANGE = 10'd126;

    localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;

    localparam int ROT_MAX = 16384;
    localparam int POS_MAX = 65535;
    localparam int POS_MIN = -65536;

    // register stages from input to the result register: trig 3, chain 3, row 4
    localparam int LAT = 10;
    // result queue; also the limit on requests in flight
    localparam int FIFO_DEPTH = 16;

    // sine polynomial, Q2.30, floored products and divisions
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        begin
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 156;
            t  = Q30_ONE - ((x2 * t) >> 30) / 110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 6;
            return (x * t) >> 30;
        end
    endfunction

    // cosine polynomial, Q2.30, clamped at zero
    function automatic logic [63:0] cos_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] d;
        begin
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 132;
            t  = Q30_ONE - ((x2 * t) >> 30) / 90;
            t  = Q30_ONE - ((x2 * t) >> 30) / 56;
            t  = Q30_ONE - ((x2 * t) >> 30) / 30;
            t  = Q30_ONE - ((x2 * t) >> 30) / 12;
            d  = ((x2 * t) >> 30) / 2;
            return (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        end
    endfunction

    // round a Q30 value to Q1.14
    function automatic logic [14:0] q30_to_q14(input logic [63:0] x);
        logic [63:0] y;
        begin
            y = (x + 64'd32768) >> 16;
            return y[14:0];
        end
    endfunction

    // a*b rounded to Q14
    function automatic t_fx mul1(input t_fx a, input t_fx b);
        logic signed [39:0] p;
        logic signed [39:0] y;
        begin
            p = a * b;
            y = (p + 40'sd8192) >>> 14;
            return y[19:0];
        end
    endfunction

    // a*b + c*d rounded to Q14
    function automatic t_fx mac2(input t_fx a, input t_fx b, input t_fx c, input t_fx d);
        logic signed [40:0] p;
        logic signed [40:0] y;
        begin
            p = a * b + c * d;
            y = (p + 41'sd8192) >>> 14;
            return y[19:0];
        end
    endfunction

    function automatic logic signed [15:0] sat_rot(input t_fx x);
        begin
            if (x > t_fx'(ROT_MAX)) begin
                return 16'(ROT_MAX);
            end else if (x < -t_fx'(ROT_MAX)) begin
                return -16'(ROT_MAX);
            end
            return x[15:0];
        end
    endfunction

    function automatic logic signed [16:0] sat_pos(input logic signed [23:0] x);
        begin
            if (x > 24'(POS_MAX)) begin
                return 17'(POS_MAX);
            end else if (x < 24'(POS_MIN)) begin
                return 17'(POS_MIN);
            end
            return x[16:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/fk_in_if.sv
// ----------------------------------------------------------------------------
// fk_in_if: joint-angle request channel
// Valid/ready channel carrying the seven joint angles of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fk_in_if #(
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] angle_a;
    logic signed [ANGLE_WIDTH-1:0] angle_b;
    logic signed [ANGLE_WIDTH-1:0] angle_c;
    logic signed [ANGLE_WIDTH-1:0] angle_d;
    logic signed [ANGLE_WIDTH-1:0] angle_e;
    logic signed [ANGLE_WIDTH-1:0] angle_f;
    logic signed [ANGLE_WIDTH-1:0] angle_g;

    modport source (
        output valid, angle_a, angle_b, angle_c, angle_d, angle_e, angle_f, angle_g,
        input  ready
    );
    modport sink (
        input  valid, angle_a, angle_b, angle_c, angle_d, angle_e, angle_f, angle_g,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/fk_out_if.sv
// ----------------------------------------------------------------------------
// fk_out_if: flange pose result channel
// Valid/ready channel carrying the rotation matrix and position of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fk_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rot_xx;
    logic signed [15:0] rot_xy;
    logic signed [15:0] rot_xz;
    logic signed [15:0] rot_yx;
    logic signed [15:0] rot_yy;
    logic signed [15:0] rot_yz;
    logic signed [15:0] rot_zx;
    logic signed [15:0] rot_zy;
    logic signed [15:0] rot_zz;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;

    modport source (
        output valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz,
               rot_zx, rot_zy, rot_zz, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz,
               rot_zx, rot_zy, rot_zz, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/fk_trig.sv
// ----------------------------------------------------------------------------
// fk_trig: joint angle to sine and cosine, three stages
// Stage 1 scales the angle to a turn phase, stage 2 maps the phase to a table
// index, stage 3 reads the quarter-wave table and applies the quadrant.
// DEPTH must be a multiple of four.
// ----------------------------------------------------------------------------
`default_nettype none

module fk_trig import fk_pkg::*; #(
    parameter int   AW    = 16,
    parameter int   DEPTH = 1024,
    parameter t_adj ADJ   = ADJ_NONE
) (
    input  wire logic                 i_clk,
    input  wire logic signed [AW-1:0] i_angle,
    output t_trig                     o_sin,
    output t_trig                     o_cos
);

    localparam int F  = AW - 3;
    localparam int PW = AW + 32;
    localparam int QD = DEPTH / 4;
    localparam int KW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int JW = $clog2(QD);
    localparam logic signed [PW-1:0] RND = PW'(1) << (F - 1);

    // quarter-wave table, built at elaboration
    logic [14:0] w_sv [QD];
    logic [14:0] w_cv [QD];

    for (genvar j = 0; j < QD; j++) begin : g_tab
        localparam logic [63:0] T = (64'(4 * j) * HALF_PI_Q30 + 64'(DEPTH / 2)) / 64'(DEPTH);
        assign w_sv[j] = q30_to_q14(sin_q30(T));
        assign w_cv[j] = q30_to_q14(cos_q30(T));
    end

    // stage 1: turn phase with the joint offset
    logic signed [PW-1:0] n_prod;
    logic [31:0]          n_phase;
    logic [31:0]          r_phase;

    always_comb begin
        n_prod = PW'(i_angle) * PW'(INV_TWO_PI_Q32) + RND;
        case (ADJ)
            ADJ_PI:  n_phase = n_prod[F+31:F] + 32'h8000_0000;
            ADJ_NEG: n_phase = 32'd0 - n_prod[F+31:F];
            default: n_phase = n_prod[F+31:F];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
    end

    // stage 2: table index for sine and cosine phase
    logic [31:0]   w_ph  [2];
    logic [IW-1:0] n_k   [2];
    logic [IW-1:0] r_k   [2];

    assign w_ph[0] = r_phase;
    assign w_ph[1] = r_phase + 32'h4000_0000;

    for (genvar n = 0; n < 2; n++) begin : g_idx
        logic [63:0]   w_pk;
        logic [KW-1:0] w_kr;
        assign w_pk = 64'(w_ph[n]) * 64'(DEPTH) + 64'h8000_0000;
        assign w_kr = w_pk[KW+31:32];
        // wrap a full turn back to zero
        assign n_k[n] = (w_kr >= KW'(DEPTH)) ? IW'(w_kr - KW'(DEPTH)) : IW'(w_kr);
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
    end

    // stage 3: quadrant split, table read, sign
    t_trig n_val [2];
    t_trig r_val [2];

    for (genvar n = 0; n < 2; n++) begin : g_lut
        logic [1:0]    w_qd;
        logic [JW-1:0] w_j;
        logic [15:0]   w_s;
        logic [15:0]   w_c;

        always_comb begin
            if (r_k[n] >= IW'(3 * QD)) begin
                w_qd = 2'd3;
                w_j  = JW'(r_k[n] - IW'(3 * QD));
            end else if (r_k[n] >= IW'(2 * QD)) begin
                w_qd = 2'd2;
                w_j  = JW'(r_k[n] - IW'(2 * QD));
            end else if (r_k[n] >= IW'(QD)) begin
                w_qd = 2'd1;
                w_j  = JW'(r_k[n] - IW'(QD));
            end else begin
                w_qd = 2'd0;
                w_j  = JW'(r_k[n]);
            end
            w_s = {1'b0, w_sv[w_j]};
            w_c = {1'b0, w_cv[w_j]};
            case (w_qd)
                2'd0:    n_val[n] = w_s;
                2'd1:    n_val[n] = w_c;
                2'd2:    n_val[n] = -w_s;
                default: n_val[n] = -w_c;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_sin = r_val[0];
    assign o_cos = r_val[1];

endmodule

`default_nettype wire

>>> rtl/core/fk_chain.sv
// ----------------------------------------------------------------------------
// fk_chain: shoulder and elbow rotation terms, three stages
// Combines the first four joints into the three row inputs of the wrist
// stages and carries the wrist sines and cosines alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module fk_chain import fk_pkg::*; (
    input  wire logic  i_clk,
    input  wire t_trig i_sin [7],
    input  wire t_trig i_cos [7],
    output t_row_in    o_row [3],
    output t_wrist     o_wrist
);

    // stage 4: single products
    t_fx    r_c0c1, r_s0c1, r_c0s1, r_s0s1, r_h0, r_s1c2;
    t_fx    r4_s0, r4_c0, r4_c1, r4_s2, r4_c2, r4_s3, r4_c3;
    t_wrist r4_wr;

    always_ff @(posedge i_clk) begin
        r_c0c1 <= mul1(t_fx'(i_cos[0]), t_fx'(i_cos[1]));
        r_s0c1 <= mul1(t_fx'(i_sin[0]), t_fx'(i_cos[1]));
        r_c0s1 <= mul1(t_fx'(i_cos[0]), t_fx'(i_sin[1]));
        r_s0s1 <= mul1(t_fx'(i_sin[0]), t_fx'(i_sin[1]));
        r_h0   <= mul1(t_fx'(i_sin[1]), t_fx'(i_sin[2]));
        r_s1c2 <= mul1(t_fx'(i_sin[1]), t_fx'(i_cos[2]));
        r4_s0  <= t_fx'(i_sin[0]);
        r4_c0  <= t_fx'(i_cos[0]);
        r4_c1  <= t_fx'(i_cos[1]);
        r4_s2  <= t_fx'(i_sin[2]);
        r4_c2  <= t_fx'(i_cos[2]);
        r4_s3  <= t_fx'(i_sin[3]);
        r4_c3  <= t_fx'(i_cos[3]);
        r4_wr  <= '{s4: i_sin[4], c4: i_cos[4], s5: i_sin[5], c5: i_cos[5],
                    s6: i_sin[6], c6: i_cos[6]};
    end

    // stage 5: first sums of products
    t_fx    r_a, r_b, r_g0, r_g3, r_g6, r_g7;
    t_fx    r5_c0s1, r5_s0s1, r5_h0, r5_c1, r5_s3, r5_c3;
    t_wrist r5_wr;

    always_ff @(posedge i_clk) begin
        r_a     <= mac2(r_c0c1, r4_c2, -r4_s0, r4_s2);
        r_b     <= mac2(r4_c0, r4_s2, r_s0c1, r4_c2);
        r_g0    <= mac2(-r_c0c1, r4_s2, -r4_s0, r4_c2);
        r_g3    <= mac2(r4_c0, r4_c2, -r_s0c1, r4_s2);
        r_g6    <= mac2(r4_c1, r4_s3, -r_s1c2, r4_c3);
        r_g7    <= mac2(r_s1c2, r4_s3, r4_c1, r4_c3);
        r5_c0s1 <= r_c0s1;
        r5_s0s1 <= r_s0s1;
        r5_h0   <= r_h0;
        r5_c1   <= r4_c1;
        r5_s3   <= r4_s3;
        r5_c3   <= r4_c3;
        r5_wr   <= r4_wr;
    end

    // stage 6: fold in joint four
    t_row_in r6_row [3];
    t_wrist  r6_wr;

    always_ff @(posedge i_clk) begin
        r6_row[0] <= '{p: r_g0, q: mac2(r5_c0s1, r5_s3, r_a, r5_c3),
                       r: mac2(r5_c0s1, r5_c3, -r_a, r5_s3), ext: r5_c0s1};
        r6_row[1] <= '{p: r_g3, q: mac2(r5_s0s1, r5_s3, r_b, r5_c3),
                       r: mac2(r5_s0s1, r5_c3, -r_b, r5_s3), ext: r5_s0s1};
        r6_row[2] <= '{p: r5_h0, q: r_g6, r: r_g7, ext: r5_c1};
        r6_wr     <= r5_wr;
    end

    assign o_row   = r6_row;
    assign o_wrist = r6_wr;

endmodule

`default_nettype wire

>>> rtl/core/fk_row.sv
// ----------------------------------------------------------------------------
// fk_row: one row of the flange pose, four stages
// Applies the three wrist joints to one row, saturates the rotation entries
// and forms the rounded position coordinate from the link lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module fk_row import fk_pkg::*; #(
    parameter bit HAS_BASE = 1'b0
) (
    input  wire logic    i_clk,
    input  wire t_cfg    i_cfg,
    input  wire t_row_in i_row,
    input  wire t_wrist  i_wrist,
    output t_row_out     o_row
);

    // stage 7: joint five
    t_fx r_u, r_v, r7_r, r7_ext;
    t_trig r7_s5, r7_c5, r7_s6, r7_c6;

    always_ff @(posedge i_clk) begin
        r_u    <= mac2(i_row.p, t_fx'(i_wrist.s4), i_row.q, t_fx'(i_wrist.c4));
        r_v    <= mac2(i_row.p, t_fx'(i_wrist.c4), -i_row.q, t_fx'(i_wrist.s4));
        r7_r   <= i_row.r;
        r7_ext <= i_row.ext;
        r7_s5  <= i_wrist.s5;
        r7_c5  <= i_wrist.c5;
        r7_s6  <= i_wrist.s6;
        r7_c6  <= i_wrist.c6;
    end

    // stage 8: joint six
    t_fx r_w, r_e2, r8_v, r8_r, r8_ext;
    t_trig r8_s6, r8_c6;

    always_ff @(posedge i_clk) begin
        r_w    <= mac2(r_u, t_fx'(r7_c5), -r7_r, t_fx'(r7_s5));
        r_e2   <= mac2(r_u, t_fx'(r7_s5), r7_r, t_fx'(r7_c5));
        r8_v   <= r_v;
        r8_r   <= r7_r;
        r8_ext <= r7_ext;
        r8_s6  <= r7_s6;
        r8_c6  <= r7_c6;
    end

    // stage 9: joint seven, saturation, link products
    logic signed [15:0] r9_rot0, r9_rot1, r9_rot2;
    logic signed [30:0] r_pf, r_pr, r_pe;

    always_ff @(posedge i_clk) begin
        r9_rot0 <= sat_rot(mac2(r8_v, t_fx'(r8_s6), r_w, t_fx'(r8_c6)));
        r9_rot1 <= sat_rot(mac2(r8_v, t_fx'(r8_c6), -r_w, t_fx'(r8_s6)));
        r9_rot2 <= sat_rot(r_e2);
        r_pf    <= $signed({1'b0, i_cfg.flange}) * r_e2;
        r_pr    <= $signed({1'b0, i_cfg.fore}) * r8_r;
        r_pe    <= $signed({1'b0, i_cfg.upper}) * r8_ext;
    end

    // stage 10: position sum, round to 1/16 mm, saturate
    logic signed [33:0] w_sum;
    logic signed [33:0] w_rnd;
    t_row_out           r_out;

    always_comb begin
        w_sum = 34'(r_pf) + 34'(r_pr) + 34'(r_pe);
        if (HAS_BASE) begin
            w_sum = w_sum + $signed({10'd0, i_cfg.base, 14'd0});
        end
        w_rnd = (w_sum + 34'sd512) >>> 10;
    end

    always_ff @(posedge i_clk) begin
        r_out <= '{rot0: r9_rot0, rot1: r9_rot1, rot2: r9_rot2, pos: sat_pos(w_rnd[23:0])};
    end

    assign o_row = r_out;

endmodule

`default_nettype wire

>>> rtl/core/forward_kinematics_7dof.sv
// ----------------------------------------------------------------------------
// forward_kinematics_7dof: flange pose of a seven-joint arm
// Takes one joint-angle request per cycle on i_joint (while ready is high) and
// returns the rotation matrix (Q1.14) and flange position (1/16 mm) on o_pose.
//
// Channels: i_joint and o_pose are valid/ready; a request moves on a clock
// edge with valid and ready both high. Link lengths are set over the APB port
// (base, upper, fore, flange at byte addresses 0, 4, 8, 12); change them only
// while no request is in flight.
// Path: a request passes 3 trig stages, 3 shoulder and elbow stages, 4 wrist
// stages, then the result queue. Throughput: one request per cycle while
// ready is high; the 10-stage datapath never stalls.
// Stall: results collect in a 16-entry queue; ready stays high while fewer
// than 16 requests are accepted and not yet delivered, so a stalled receiver
// holds off new requests only once that many are outstanding.
// Reset: clears the pipeline valids, the queue and the outstanding count and
// loads the default link lengths 360, 420, 400 and 126 mm.
// ----------------------------------------------------------------------------
`default_nettype none

module forward_kinematics_7dof import fk_pkg::*; #(
    parameter int ANGLE_WIDTH      = 16,
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fk_in_if.sink            i_joint,
    fk_out_if.source         o_pose,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int PW = $clog2(FIFO_DEPTH);

    // configuration registers
    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{base: RST_BASE, upper: RST_UPPER, fore: RST_FORE, flange: RST_FLANGE};
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_BASE:   r_cfg.base   <= pwdata[9:0];
                REG_UPPER:  r_cfg.upper  <= pwdata[9:0];
                REG_FORE:   r_cfg.fore   <= pwdata[9:0];
                REG_FLANGE: r_cfg.flange <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_BASE:   prdata = {22'd0, r_cfg.base};
            REG_UPPER:  prdata = {22'd0, r_cfg.upper};
            REG_FORE:   prdata = {22'd0, r_cfg.fore};
            REG_FLANGE: prdata = {22'd0, r_cfg.flange};
            default:    prdata = '0;
        endcase
    end

    // trig stages, one unit per joint
    logic signed [ANGLE_WIDTH-1:0] w_ang [7];
    t_trig w_sin [7];
    t_trig w_cos [7];

    assign w_ang[0] = i_joint.angle_a;
    assign w_ang[1] = i_joint.angle_b;
    assign w_ang[2] = i_joint.angle_c;
    assign w_ang[3] = i_joint.angle_d;
    assign w_ang[4] = i_joint.angle_e;
    assign w_ang[5] = i_joint.angle_f;
    assign w_ang[6] = i_joint.angle_g;

    for (genvar i = 0; i < 7; i++) begin : g_joint
        localparam t_adj ADJ = (i == 2 || i == 4) ? ADJ_PI :
                               (i == 3) ? ADJ_NEG : ADJ_NONE;
        fk_trig #(
            .AW    (ANGLE_WIDTH),
            .DEPTH (TRIG_TABLE_DEPTH),
            .ADJ   (ADJ)
        ) u_trig (
            .i_clk   (i_clk),
            .i_angle (w_ang[i]),
            .o_sin   (w_sin[i]),
            .o_cos   (w_cos[i])
        );
    end

    // shoulder and elbow terms
    t_row_in w_row [3];
    t_wrist  w_wrist;

    fk_chain u_chain (
        .i_clk   (i_clk),
        .i_sin   (w_sin),
        .i_cos   (w_cos),
        .o_row   (w_row),
        .o_wrist (w_wrist)
    );

    // wrist stages, one per pose row
    t_row_out w_out [3];

    for (genvar r = 0; r < 3; r++) begin : g_row
        fk_row #(
            .HAS_BASE (r == 2)
        ) u_row (
            .i_clk   (i_clk),
            .i_cfg   (r_cfg),
            .i_row   (w_row[r]),
            .i_wrist (w_wrist),
            .o_row   (w_out[r])
        );
    end

    // request and result handshakes
    logic w_in_acc;
    logic w_out_acc;
    logic w_wr;

    assign w_in_acc  = i_joint.valid & i_joint.ready;
    assign w_out_acc = o_pose.valid & o_pose.ready;

    // valid bits travel with the datapath
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_in_acc};
        end
    end

    assign w_wr = r_vld[LAT-1];

    // result queue and outstanding count
    t_pose          r_fifo [FIFO_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_fill;
    logic [CW-1:0]  r_cnt;
    t_pose          w_wdata;
    t_pose          w_head;

    assign w_wdata = '{
        rot_xx: w_out[0].rot0, rot_xy: w_out[0].rot1, rot_xz: w_out[0].rot2,
        rot_yx: w_out[1].rot0, rot_yy: w_out[1].rot1, rot_yz: w_out[1].rot2,
        rot_zx: w_out[2].rot0, rot_zy: w_out[2].rot1, rot_zz: w_out[2].rot2,
        pos_x:  w_out[0].pos,  pos_y:  w_out[1].pos,  pos_z:  w_out[2].pos
    };

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_fifo[r_wp] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + PW'(1);
            end
            if (w_out_acc) begin
                r_rp <= r_rp + PW'(1);
            end
            r_fill <= r_fill + CW'(w_wr) - CW'(w_out_acc);
            r_cnt  <= r_cnt + CW'(w_in_acc) - CW'(w_out_acc);
        end
    end

    // accept while the queue has room for every outstanding request
    assign i_joint.ready = (r_cnt < CW'(FIFO_DEPTH));

    assign w_head        = r_fifo[r_rp];
    assign o_pose.valid  = (r_fill != '0);
    assign o_pose.rot_xx = w_head.rot_xx;
    assign o_pose.rot_xy = w_head.rot_xy;
    assign o_pose.rot_xz = w_head.rot_xz;
    assign o_pose.rot_yx = w_head.rot_yx;
    assign o_pose.rot_yy = w_head.rot_yy;
    assign o_pose.rot_yz = w_head.rot_yz;
    assign o_pose.rot_zx = w_head.rot_zx;
    assign o_pose.rot_zy = w_head.rot_zy;
    assign o_pose.rot_zz = w_head.rot_zz;
    assign o_pose.pos_x  = w_head.pos_x;
    assign o_pose.pos_y  = w_head.pos_y;
    assign o_pose.pos_z  = w_head.pos_z;

    // every outstanding request is either in the datapath or in the queue
    a_count_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'($countones(r_vld)) + r_fill == r_cnt)
        else $error("outstanding count does not match datapath and queue");

    // the queue never holds more than the outstanding requests
    a_fill_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cnt)
        else $error("queue fill exceeds outstanding count");

    // a result leaving the datapath always finds room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> (r_fill < CW'(FIFO_DEPTH)))
        else $error("result written into a full queue");

    // ready drops only when the outstanding limit is reached
    a_ready_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_joint.ready |-> (r_cnt == CW'(FIFO_DEPTH)))
        else $error("request refused below the outstanding limit");

endmodule

`default_nettype wire
